@@ hdl/csr_pkg.sv @@
// ----------------------------------------------------------------------------
// csr_pkg: shared types and constants for the color string resolver
// Item and result structs, status codes and the color name ROM.
// ----------------------------------------------------------------------------
`default_nettype none

package csr_pkg;

  localparam int NUM_NAMES  = 24;
  localparam int NAME_BITS  = 96;   // 12 characters, right-justified, zero padded

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_LEN_ERR = 2'd1,
    ST_HEX_ERR = 2'd2,
    ST_UNKNOWN = 2'd3
  } csr_status_e;

  // Classified character as handed from front to back
  typedef struct packed {
    logic [7:0] lc;        // lower-cased character
    logic [3:0] nib;       // hex value, 0 when not a hex digit
    logic       is_hex;
    logic       is_hash;
    logic       has_char;
    logic       is_last;
  } csr_item_t;

  typedef struct packed {
    logic [7:0]  red;
    logic [7:0]  green;
    logic [7:0]  blue;
    logic [7:0]  alpha;
    csr_status_e status;
  } csr_result_t;

  localparam logic [7:0] CH_HASH = 8'h23;

  // Name text: last character in the low byte
  localparam logic [NAME_BITS-1:0] NAME_TEXT [NUM_NAMES] = '{
    "aqua", "black", "blue", "cyan", "fuchsia", "gray", "green", "grey",
    "lime", "magenta", "maroon", "navy", "olive", "orange", "purple", "red",
    "silver", "teal", "transparent", "turquoise", "violet", "white", "yellow",
    "yellowgreen"
  };

  localparam logic [3:0] NAME_LEN [NUM_NAMES] = '{
    4'd4, 4'd5, 4'd4, 4'd4, 4'd7, 4'd4, 4'd5, 4'd4,
    4'd4, 4'd7, 4'd6, 4'd4, 4'd5, 4'd6, 4'd6, 4'd3,
    4'd6, 4'd4, 4'd11, 4'd9, 4'd6, 4'd5, 4'd6, 4'd11
  };

  localparam logic [7:0] NAME_R [NUM_NAMES] = '{
    8'd0, 8'd0, 8'd0, 8'd0, 8'd255, 8'd128, 8'd0, 8'd128,
    8'd0, 8'd255, 8'd128, 8'd0, 8'd128, 8'd255, 8'd128, 8'd255,
    8'd191, 8'd0, 8'd0, 8'd64, 8'd238, 8'd255, 8'd255, 8'd154
  };

  localparam logic [7:0] NAME_G [NUM_NAMES] = '{
    8'd255, 8'd0, 8'd0, 8'd255, 8'd0, 8'd128, 8'd128, 8'd128,
    8'd255, 8'd0, 8'd0, 8'd0, 8'd128, 8'd165, 8'd0, 8'd0,
    8'd191, 8'd128, 8'd0, 8'd224, 8'd130, 8'd255, 8'd255, 8'd205
  };

  localparam logic [7:0] NAME_B [NUM_NAMES] = '{
    8'd255, 8'd0, 8'd255, 8'd255, 8'd255, 8'd128, 8'd0, 8'd128,
    8'd0, 8'd255, 8'd0, 8'd128, 8'd0, 8'd0, 8'd128, 8'd0,
    8'd191, 8'd128, 8'd0, 8'd208, 8'd238, 8'd255, 8'd0, 8'd50
  };

  localparam logic [7:0] NAME_A [NUM_NAMES] = '{
    8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255,
    8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255,
    8'd255, 8'd255, 8'd0, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255
  };

endpackage

`default_nettype wire

@@ hdl/csr_front.sv @@
// ----------------------------------------------------------------------------
// csr_front: character intake and classification
// Registers each beat, lower-cases it, decodes hex and drops idle terminators.
// ----------------------------------------------------------------------------
`default_nettype none

module csr_front
  import csr_pkg::*;
(
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire logic      in_valid_i,
  output logic           in_ready_o,
  input  wire logic [7:0] in_ch_i,
  input  wire logic      in_has_char_i,
  input  wire logic      in_last_i,
  output logic           q_valid_o,
  input  wire logic      q_ready_i,
  output csr_item_t      q_item_o
);

  logic      vld_q;
  csr_item_t item_q, item_d;
  logic      keep;

  always_comb begin
    item_d          = '0;
    item_d.has_char = in_has_char_i;
    item_d.is_last  = in_last_i;
    item_d.is_hash  = (in_ch_i == CH_HASH);
    item_d.lc       = (in_ch_i >= "A" && in_ch_i <= "Z") ? (in_ch_i | 8'h20) : in_ch_i;
    if (in_ch_i >= "0" && in_ch_i <= "9") begin
      item_d.is_hex = 1'b1;
      item_d.nib    = in_ch_i[3:0];
    end else if (item_d.lc >= "a" && item_d.lc <= "f") begin
      item_d.is_hex = 1'b1;
      item_d.nib    = item_d.lc[3:0] + 4'd9;
    end
  end

  // a terminator that is not last does nothing downstream
  assign keep       = item_q.has_char | item_q.is_last;
  assign q_valid_o  = vld_q & keep;
  assign q_item_o   = item_q;
  assign in_ready_o = ~vld_q | ~keep | q_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else if (in_ready_o) begin
      vld_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      item_q <= item_d;
    end
  end

endmodule

`default_nettype wire

@@ hdl/csr_fifo.sv @@
// ----------------------------------------------------------------------------
// csr_fifo: short queue of classified characters
// Decouples the front from the back; flip-flop storage, read at the head.
// ----------------------------------------------------------------------------
`default_nettype none

module csr_fifo
  import csr_pkg::*;
#(
  parameter int DEPTH = 4
) (
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire logic      push_i,
  input  wire csr_item_t push_item_i,
  output logic           push_ready_o,
  input  wire logic      pop_i,
  output csr_item_t      pop_item_o,
  output logic           pop_valid_o
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [AW-1:0] LAST_IDX = AW'(DEPTH - 1);
  localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

  csr_item_t         mem_q [DEPTH];
  logic [AW-1:0]     wr_q, rd_q;
  logic [CW-1:0]     cnt_q;
  logic              do_push, do_pop;

  assign push_ready_o = (cnt_q != FULL_CNT);
  assign pop_valid_o  = (cnt_q != '0);
  assign pop_item_o   = mem_q[rd_q];
  assign do_push      = push_i & push_ready_o;
  assign do_pop       = pop_i & pop_valid_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (do_push) begin
        wr_q <= (wr_q == LAST_IDX) ? '0 : wr_q + 1'b1;
      end
      if (do_pop) begin
        rd_q <= (rd_q == LAST_IDX) ? '0 : rd_q + 1'b1;
      end
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (do_pop && !do_push) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_q] <= push_item_i;
    end
  end

endmodule

`default_nettype wire

@@ hdl/csr_back.sv @@
// ----------------------------------------------------------------------------
// csr_back: string state and result generation
// Tracks hex digits and 24 name matches; resolves and registers the result.
// ----------------------------------------------------------------------------
`default_nettype none

module csr_back
  import csr_pkg::*;
(
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire logic      q_valid_i,
  input  wire csr_item_t q_item_i,
  output logic           q_pop_o,
  output logic           res_valid_o,
  input  wire logic      res_ready_i,
  output csr_result_t    res_o
);

  logic                 hash_q, hash_d;
  logic                 seen_q, seen_d;
  logic [3:0]           cnt_q, cnt_d;
  logic [31:0]          acc_q, acc_d;
  logic                 bad_q, bad_d;
  logic [NUM_NAMES-1:0] match_q, match_d;
  logic                 out_vld_q;
  csr_result_t          out_q, res_d;

  logic                 out_free;

  assign out_free    = ~out_vld_q | res_ready_i;
  assign q_pop_o     = q_valid_i & (~q_item_i.is_last | out_free);
  assign res_valid_o = out_vld_q;
  assign res_o       = out_q;

  always_comb begin
    logic [6:0]  base;
    logic [7:0]  rom_c;
    logic        found;
    logic [4:0]  sel;

    hash_d  = hash_q;
    seen_d  = seen_q;
    cnt_d   = cnt_q;
    acc_d   = acc_q;
    bad_d   = bad_q;
    match_d = match_q;
    res_d   = '0;
    found   = 1'b0;
    sel     = '0;
    base    = '0;
    rom_c   = '0;

    if (q_item_i.has_char) begin
      if (!seen_q) begin
        seen_d = 1'b1;
        hash_d = q_item_i.is_hash;
      end else if (hash_q) begin
        acc_d = {acc_q[27:0], q_item_i.nib};
        bad_d = bad_q | ~q_item_i.is_hex;
      end
      if (!hash_d) begin
        for (int i = 0; i < NUM_NAMES; i++) begin
          rom_c = 8'h00;
          if (cnt_q < NAME_LEN[i]) begin
            base  = {NAME_LEN[i] - cnt_q - 4'd1, 3'b000};
            rom_c = NAME_TEXT[i][base +: 8];
          end
          if (!(cnt_q < NAME_LEN[i]) || rom_c != q_item_i.lc) begin
            match_d[i] = 1'b0;
          end
        end
      end
      if (cnt_q != 4'd15) begin
        cnt_d = cnt_q + 4'd1;
      end
    end

    // result from the state after this character
    if (seen_d && hash_d) begin
      if (cnt_d == 4'd7) begin
        if (bad_d) begin
          res_d.status = ST_HEX_ERR;
        end else begin
          res_d.red    = acc_d[23:16];
          res_d.green  = acc_d[15:8];
          res_d.blue   = acc_d[7:0];
          res_d.alpha  = 8'd255;
          res_d.status = ST_OK;
        end
      end else if (cnt_d == 4'd9) begin
        if (bad_d) begin
          res_d.status = ST_HEX_ERR;
        end else begin
          res_d.red    = acc_d[31:24];
          res_d.green  = acc_d[23:16];
          res_d.blue   = acc_d[15:8];
          res_d.alpha  = acc_d[7:0];
          res_d.status = ST_OK;
        end
      end else begin
        res_d.status = ST_LEN_ERR;
      end
    end else begin
      for (int i = NUM_NAMES - 1; i >= 0; i--) begin
        if (match_d[i] && NAME_LEN[i] == cnt_d) begin
          found = 1'b1;
          sel   = 5'(i);
        end
      end
      if (found) begin
        res_d.red    = NAME_R[sel];
        res_d.green  = NAME_G[sel];
        res_d.blue   = NAME_B[sel];
        res_d.alpha  = NAME_A[sel];
        res_d.status = ST_OK;
      end else begin
        res_d.status = ST_UNKNOWN;
      end
    end

    // the string ends here: start over
    if (q_item_i.is_last) begin
      hash_d  = 1'b0;
      seen_d  = 1'b0;
      cnt_d   = '0;
      acc_d   = '0;
      bad_d   = 1'b0;
      match_d = '1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hash_q    <= 1'b0;
      seen_q    <= 1'b0;
      cnt_q     <= '0;
      acc_q     <= '0;
      bad_q     <= 1'b0;
      match_q   <= '1;
      out_vld_q <= 1'b0;
    end else begin
      if (q_pop_o) begin
        hash_q  <= hash_d;
        seen_q  <= seen_d;
        cnt_q   <= cnt_d;
        acc_q   <= acc_d;
        bad_q   <= bad_d;
        match_q <= match_d;
      end
      if (q_pop_o && q_item_i.is_last) begin
        out_vld_q <= 1'b1;
      end else if (res_ready_i) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (q_pop_o && q_item_i.is_last) begin
      out_q <= res_d;
    end
  end

endmodule

`default_nettype wire

@@ hdl/color_string_resolver.sv @@
// ----------------------------------------------------------------------------
// color_string_resolver: color string to RGBA
// Streams a color string, one character per beat, and returns one RGBA
// result on the beat marked last: '#' plus 6 or 8 hex digits, or one of
// 24 named colors (case-insensitive).
// ----------------------------------------------------------------------------
//
//   channel   dir  tdata                          tuser      tlast
//   s_axis    in   ch[7:0]                        has_char   is_last
//   m_axis    out  red,green,blue,alpha,status    -          -
//
// Throughput: one character beat per cycle while m_axis takes results, with a
// result beat on every last character; the back unit retires one character per
// cycle, but a last character waits while a result is held on m_axis.
// Path: a last beat passes the front register, the queue and the result register.
// Reset: rst_ni clears all control state; no clearing pass is needed.
// Stalls: the front keeps taking beats while a result waits on m_axis,
// until the queue of QUEUE_DEPTH entries fills; only last beats wait on the
// result register, other characters drain past a stalled output.
// ----------------------------------------------------------------------------
`default_nettype none

module color_string_resolver
  import csr_pkg::*;
#(
  parameter int QUEUE_DEPTH = 4
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  // input characters
  input  wire logic        s_axis_tvalid_i,
  output logic             s_axis_tready_o,
  input  wire logic [7:0]  s_axis_tdata_i,   // [7:0] ch
  input  wire logic        s_axis_tuser_i,   // [0] has_char
  input  wire logic        s_axis_tlast_i,   // is_last
  // results
  output logic             m_axis_tvalid_o,
  input  wire logic        m_axis_tready_i,
  output logic [39:0]      m_axis_tdata_o    // [7:0] red, [15:8] green,
                                             // [23:16] blue, [31:24] alpha,
                                             // [33:32] status, [39:34] zero
);

  logic        frt_valid, frt_ready;
  csr_item_t   frt_item;
  logic        q_valid, q_pop;
  csr_item_t   q_item;
  csr_result_t res;

  // intake and classification
  csr_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (s_axis_tvalid_i),
    .in_ready_o    (s_axis_tready_o),
    .in_ch_i       (s_axis_tdata_i),
    .in_has_char_i (s_axis_tuser_i),
    .in_last_i     (s_axis_tlast_i),
    .q_valid_o     (frt_valid),
    .q_ready_i     (frt_ready),
    .q_item_o      (frt_item)
  );

  // decoupling queue
  csr_fifo #(
    .DEPTH (QUEUE_DEPTH)
  ) u_fifo (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (frt_valid),
    .push_item_i  (frt_item),
    .push_ready_o (frt_ready),
    .pop_i        (q_pop),
    .pop_item_o   (q_item),
    .pop_valid_o  (q_valid)
  );

  // string state, resolution and result register
  csr_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_valid_i   (q_valid),
    .q_item_i    (q_item),
    .q_pop_o     (q_pop),
    .res_valid_o (m_axis_tvalid_o),
    .res_ready_i (m_axis_tready_i),
    .res_o       (res)
  );

  assign m_axis_tdata_o = {6'b000000, res.status, res.alpha, res.blue, res.green, res.red};

endmodule

`default_nettype wire
